/* rtl/aas_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aas_pkg: shared types and constants for adaptive axis smoothing
// Widths, weight constants, register indexes, controller states and the
// request/response bundles of the bit-serial divider and multiplier.
// ----------------------------------------------------------------------------
package aas_pkg;

   // Geometry of the sample stream.
   localparam int AXIS_COUNT  = 3;
   localparam int SAMPLE_BITS = 16;

   // Q1.16 weights, where one is 2^FRAC_BITS and needs one extra bit.
   localparam int FRAC_BITS = 16;
   localparam int WEIGHT_W  = FRAC_BITS + 1;
   localparam int DIST_W    = 16;
   localparam int CFG_W     = (WEIGHT_W > DIST_W) ? WEIGHT_W : DIST_W;
   localparam int CMP_W     = (SAMPLE_BITS > DIST_W) ? SAMPLE_BITS : DIST_W;

   // Serial multiplier operand, partial-sum and product widths.
   localparam int OPA_W    = (SAMPLE_BITS > WEIGHT_W) ? SAMPLE_BITS : WEIGHT_W;
   localparam int MUL_HI_W = OPA_W + 2;
   localparam int PROD_W   = MUL_HI_W + WEIGHT_W;

   // Both serial units retire one bit per cycle over WEIGHT_W steps.
   localparam int CNT_W      = $clog2(WEIGHT_W);
   localparam int AXIS_IDX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
   localparam int CSR_IDX_W  = 1;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [WEIGHT_W-1:0]    weight_type;
   typedef logic [DIST_W-1:0]      dist_type;
   typedef logic [OPA_W-1:0]       opa_type;
   typedef logic [PROD_W-1:0]      prod_type;
   typedef logic [CSR_IDX_W-1:0]   csr_idx_type;

   localparam weight_type ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
   localparam sample_type SIGN_MASK = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // Configuration register indexes.
   localparam csr_idx_type CSR_BLEND_FACTOR    = 1'b0;
   localparam csr_idx_type CSR_JITTER_DISTANCE = 1'b1;

   // Controller states, one-hot.
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DIV   = 7'b0000010,
      ST_SQR   = 7'b0000100,
      ST_CUBE  = 7'b0001000,
      ST_WGT   = 7'b0010000,
      ST_BLEND = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   // Divider bundles.
   typedef struct packed {
      logic     start;
      dist_type numer;
      dist_type denom;
   } div_req_type;

   typedef struct packed {
      logic       done;
      weight_type quot;
   } div_rsp_type;

   // Multiplier bundles: the unit forms a0 * b0 + a1 * b1.
   typedef struct packed {
      logic       start;
      opa_type    a0;
      weight_type b0;
      opa_type    a1;
      weight_type b1;
   } mul_req_type;

   typedef struct packed {
      logic     done;
      prod_type prod;
   } mul_rsp_type;

endpackage

/* rtl/aas_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aas_div: bit-serial restoring divider
// Forms floor(numer * 2^16 / denom) for numer <= denom, one quotient bit per
// cycle, most significant bit first.
// ----------------------------------------------------------------------------
module aas_div (
   input  logic                clock,
   input  logic                reset,
   input  aas_pkg::div_req_type div_req,
   output aas_pkg::div_rsp_type div_rsp
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic                     first_ff, first_in;
   logic [aas_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   aas_pkg::dist_type        rem_ff, rem_in;
   aas_pkg::dist_type        denom_ff, denom_in;
   aas_pkg::weight_type      quot_ff, quot_in;

   logic [aas_pkg::DIST_W:0] trial;
   logic [aas_pkg::DIST_W:0] diff;
   logic                     fits;

   // The first step compares the numerator itself; later steps shift in a zero.
   always_comb begin
      trial = first_ff ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      diff  = trial - {1'b0, denom_ff};
      fits  = (trial >= {1'b0, denom_ff});
   end

   // Step sequencing and next values.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      first_in = first_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      denom_in = denom_ff;
      quot_in  = quot_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         first_in = 1'b1;
         cnt_in   = '0;
         rem_in   = div_req.numer;
         denom_in = div_req.denom;
      end else if (busy_ff) begin
         first_in = 1'b0;
         rem_in   = fits ? diff[aas_pkg::DIST_W-1:0] : trial[aas_pkg::DIST_W-1:0];
         quot_in  = {quot_ff[aas_pkg::WEIGHT_W-2:0], fits};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == aas_pkg::CNT_W'(aas_pkg::WEIGHT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      first_ff <= first_in;
      rem_ff   <= rem_in;
      denom_ff <= denom_in;
      quot_ff  <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

/* rtl/aas_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aas_mul: bit-serial dual-product multiplier
// Forms a0 * b0 + a1 * b1 by scanning one bit of each b operand per cycle,
// least significant bit first, and shifting the partial sum right.
// ----------------------------------------------------------------------------
module aas_mul (
   input  logic                clock,
   input  logic                reset,
   input  aas_pkg::mul_req_type mul_req,
   output aas_pkg::mul_rsp_type mul_rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [aas_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   aas_pkg::opa_type              a0_ff, a0_in;
   aas_pkg::opa_type              a1_ff, a1_in;
   aas_pkg::weight_type           b0_ff, b0_in;
   aas_pkg::weight_type           b1_ff, b1_in;
   logic [aas_pkg::MUL_HI_W-1:0]  hi_ff, hi_in;
   aas_pkg::weight_type           lo_ff, lo_in;

   logic [aas_pkg::MUL_HI_W-1:0] part0;
   logic [aas_pkg::MUL_HI_W-1:0] part1;
   logic [aas_pkg::MUL_HI_W-1:0] total;

   // Add the selected multiplicands to the upper half of the partial sum.
   always_comb begin
      part0 = b0_ff[0] ? aas_pkg::MUL_HI_W'(a0_ff) : '0;
      part1 = b1_ff[0] ? aas_pkg::MUL_HI_W'(a1_ff) : '0;
      total = hi_ff + part0 + part1;
   end

   // Step sequencing and next values.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a0_in   = a0_ff;
      a1_in   = a1_ff;
      b0_in   = b0_ff;
      b1_in   = b1_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      if (mul_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a0_in   = mul_req.a0;
         a1_in   = mul_req.a1;
         b0_in   = mul_req.b0;
         b1_in   = mul_req.b1;
         hi_in   = '0;
         lo_in   = '0;
      end else if (busy_ff) begin
         hi_in  = {1'b0, total[aas_pkg::MUL_HI_W-1:1]};
         lo_in  = {total[0], lo_ff[aas_pkg::WEIGHT_W-1:1]};
         b0_in  = {1'b0, b0_ff[aas_pkg::WEIGHT_W-1:1]};
         b1_in  = {1'b0, b1_ff[aas_pkg::WEIGHT_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == aas_pkg::CNT_W'(aas_pkg::WEIGHT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      a0_ff <= a0_in;
      a1_ff <= a1_in;
      b0_ff <= b0_in;
      b1_ff <= b1_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.prod = {hi_ff, lo_ff};

endmodule

/* rtl/adaptive_axis_smoothing_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_axis_smoothing_top: adaptive exponential smoothing of three axes
// One request is processed at a time; a new one is taken only in the idle
// state, once the bit-serial divider and multiplier have done every axis.
// The output register lets the next request in while a result waits.
// Synchronous reset clears the held values, both registers and all valids.
// ----------------------------------------------------------------------------
module adaptive_axis_smoothing_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [aas_pkg::SAMPLE_BITS-1:0] req_sample_x,
   input  logic signed [aas_pkg::SAMPLE_BITS-1:0] req_sample_y,
   input  logic signed [aas_pkg::SAMPLE_BITS-1:0] req_sample_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [aas_pkg::SAMPLE_BITS-1:0] rsp_filtered_x,
   output logic signed [aas_pkg::SAMPLE_BITS-1:0] rsp_filtered_y,
   output logic signed [aas_pkg::SAMPLE_BITS-1:0] rsp_filtered_z,
   input  logic                                   csr_write_en,
   input  logic [aas_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [aas_pkg::CFG_W-1:0]              csr_data
);

   aas_pkg::state_type              state_ff, state_in;
   logic [aas_pkg::AXIS_IDX_W-1:0] axis_ff, axis_in;
   logic                           start_ff, start_in;
   aas_pkg::weight_type            x_ff, x_in;
   aas_pkg::weight_type            pow_ff, pow_in;
   aas_pkg::weight_type            k_ff, k_in;
   aas_pkg::weight_type            blend_factor_ff, blend_factor_in;
   aas_pkg::dist_type              jitter_distance_ff, jitter_distance_in;
   aas_pkg::sample_type            held_ff [aas_pkg::AXIS_COUNT];
   aas_pkg::sample_type            held_in [aas_pkg::AXIS_COUNT];
   aas_pkg::sample_type            sample_ff [aas_pkg::AXIS_COUNT];
   aas_pkg::sample_type            sample_in [aas_pkg::AXIS_COUNT];
   aas_pkg::sample_type            rsp_data_ff [aas_pkg::AXIS_COUNT];
   aas_pkg::sample_type            rsp_data_in [aas_pkg::AXIS_COUNT];
   logic                           rsp_valid_ff, rsp_valid_in;

   aas_pkg::div_req_type div_req;
   aas_pkg::div_rsp_type div_rsp;
   aas_pkg::mul_req_type mul_req;
   aas_pkg::mul_rsp_type mul_rsp;

   aas_pkg::sample_type          held_b;
   aas_pkg::sample_type          samp_b;
   aas_pkg::sample_type          diff;
   logic [aas_pkg::CMP_W-1:0]    diff_ext;
   logic [aas_pkg::CMP_W-1:0]    dist_ext;
   logic                         adapt;
   aas_pkg::weight_type          factor;
   logic                         req_accept;

   assign req_accept = req_valid && req_ready;

   // Current axis in offset binary, its distance and the effective factor.
   always_comb begin
      held_b   = held_ff[axis_ff] ^ aas_pkg::SIGN_MASK;
      samp_b   = sample_ff[axis_ff] ^ aas_pkg::SIGN_MASK;
      diff     = (held_b >= samp_b) ? (held_b - samp_b) : (samp_b - held_b);
      diff_ext = aas_pkg::CMP_W'(diff);
      dist_ext = aas_pkg::CMP_W'(jitter_distance_ff);
      adapt    = (jitter_distance_ff != '0) && (diff_ext < dist_ext);
      factor   = (blend_factor_ff > aas_pkg::ONE_Q) ? '0 : blend_factor_ff;
   end

   // Divider operands: (distance - difference) over distance.
   always_comb begin
      div_req.start = start_ff && (state_ff == aas_pkg::ST_DIV);
      div_req.numer = adapt ? aas_pkg::DIST_W'(dist_ext - diff_ext) : '0;
      div_req.denom = jitter_distance_ff;
   end

   // Multiplier operands for each step of the weight and the blend.
   always_comb begin
      mul_req.start = start_ff && (state_ff != aas_pkg::ST_DIV);
      mul_req.a0    = '0;
      mul_req.b0    = '0;
      mul_req.a1    = '0;
      mul_req.b1    = '0;
      case (state_ff)
         aas_pkg::ST_SQR: begin
            mul_req.a0 = aas_pkg::OPA_W'(x_ff);
            mul_req.b0 = x_ff;
         end
         aas_pkg::ST_CUBE: begin
            mul_req.a0 = aas_pkg::OPA_W'(pow_ff);
            mul_req.b0 = x_ff;
         end
         aas_pkg::ST_WGT: begin
            mul_req.a0 = aas_pkg::OPA_W'(pow_ff);
            mul_req.b0 = aas_pkg::ONE_Q - factor;
         end
         aas_pkg::ST_BLEND: begin
            mul_req.a0 = aas_pkg::OPA_W'(held_b);
            mul_req.b0 = k_ff;
            mul_req.a1 = aas_pkg::OPA_W'(samp_b);
            mul_req.b1 = aas_pkg::ONE_Q - k_ff;
         end
         default: begin
         end
      endcase
   end

   aas_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   aas_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   // Configuration writes.
   always_comb begin
      blend_factor_in    = blend_factor_ff;
      jitter_distance_in = jitter_distance_ff;
      if (csr_write_en) begin
         case (csr_index)
            aas_pkg::CSR_BLEND_FACTOR:    blend_factor_in = csr_data[aas_pkg::WEIGHT_W-1:0];
            aas_pkg::CSR_JITTER_DISTANCE: jitter_distance_in = csr_data[aas_pkg::DIST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Request capture.
   always_comb begin
      sample_in = sample_ff;
      if (req_accept) begin
         sample_in[0] = req_sample_x;
         sample_in[1] = req_sample_y;
         sample_in[2] = req_sample_z;
      end
   end

   // Sequencer: per axis, divide, square, cube, weight, then blend.
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      start_in     = 1'b0;
      x_in         = x_ff;
      pow_in       = pow_ff;
      k_in         = k_ff;
      held_in      = held_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         aas_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = aas_pkg::ST_DIV;
               axis_in  = '0;
               start_in = 1'b1;
            end
         end
         aas_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               x_in     = adapt ? div_rsp.quot : '0;
               state_in = aas_pkg::ST_SQR;
               start_in = 1'b1;
            end
         end
         aas_pkg::ST_SQR: begin
            if (mul_rsp.done) begin
               pow_in   = mul_rsp.prod[aas_pkg::FRAC_BITS +: aas_pkg::WEIGHT_W];
               state_in = aas_pkg::ST_CUBE;
               start_in = 1'b1;
            end
         end
         aas_pkg::ST_CUBE: begin
            if (mul_rsp.done) begin
               pow_in   = mul_rsp.prod[aas_pkg::FRAC_BITS +: aas_pkg::WEIGHT_W];
               state_in = aas_pkg::ST_WGT;
               start_in = 1'b1;
            end
         end
         aas_pkg::ST_WGT: begin
            if (mul_rsp.done) begin
               k_in     = factor + mul_rsp.prod[aas_pkg::FRAC_BITS +: aas_pkg::WEIGHT_W];
               state_in = aas_pkg::ST_BLEND;
               start_in = 1'b1;
            end
         end
         aas_pkg::ST_BLEND: begin
            if (mul_rsp.done) begin
               held_in[axis_ff] = mul_rsp.prod[aas_pkg::FRAC_BITS +: aas_pkg::SAMPLE_BITS]
                                  ^ aas_pkg::SIGN_MASK;
               if (axis_ff == aas_pkg::AXIS_IDX_W'(aas_pkg::AXIS_COUNT - 1)) begin
                  state_in = aas_pkg::ST_DONE;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = aas_pkg::ST_DIV;
                  start_in = 1'b1;
               end
            end
         end
         aas_pkg::ST_DONE: begin
            // Load the output register once the previous result has gone.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = held_ff;
               rsp_valid_in = 1'b1;
               state_in     = aas_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aas_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state, configuration and held values.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= aas_pkg::ST_IDLE;
         axis_ff            <= '0;
         start_ff           <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         blend_factor_ff    <= '0;
         jitter_distance_ff <= '0;
         for (int i = 0; i < aas_pkg::AXIS_COUNT; i++) begin
            held_ff[i] <= '0;
         end
      end else begin
         state_ff           <= state_in;
         axis_ff            <= axis_in;
         start_ff           <= start_in;
         rsp_valid_ff       <= rsp_valid_in;
         blend_factor_ff    <= blend_factor_in;
         jitter_distance_ff <= jitter_distance_in;
         held_ff            <= held_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      pow_ff      <= pow_in;
      k_ff        <= k_in;
      sample_ff   <= sample_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready      = (state_ff == aas_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_filtered_x = rsp_data_ff[0];
   assign rsp_filtered_y = rsp_data_ff[1];
   assign rsp_filtered_z = rsp_data_ff[2];

endmodule

/* rtl/aas_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aas_checker: port-level checks for adaptive axis smoothing
// Watches the request and response handshakes of the top level and is bound
// to it below.
// ----------------------------------------------------------------------------
module aas_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [aas_pkg::SAMPLE_BITS-1:0] rsp_filtered_x,
   input logic signed [aas_pkg::SAMPLE_BITS-1:0] rsp_filtered_y,
   input logic signed [aas_pkg::SAMPLE_BITS-1:0] rsp_filtered_z
);

   // A stalled response keeps its valid and its values.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filtered_x)
         && $stable(rsp_filtered_y) && $stable(rsp_filtered_z))
      else $error("response changed while stalled");

   // The engine works on one request at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the engine is busy");

   // A new result appears only as the engine returns to idle.
   a_rsp_at_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready && !$past(req_ready))
      else $error("result loaded outside the end of a computation");

   // Reset leaves the block idle with no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind adaptive_axis_smoothing_top aas_checker u_aas_checker (.*);

/* verif/adaptive_axis_smoothing_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_axis_smoothing_top_test: self-checking bench for axis smoothing
// A clocked driver feeds sample requests from a queue, while a clocked
// monitor compares each filtered result with a prediction computed when the
// request was accepted. Directed corner cases come first, followed by random
// phases under varied weight settings, random idling and one long back-pressure
// stretch that fills the block.
// ----------------------------------------------------------------------------
module adaptive_axis_smoothing_top_test;
   import aas_pkg::*;

   typedef struct packed {
      sample_type x;
      sample_type y;
      sample_type z;
   } triple_type;

   // Receiver back-pressure: one long hold-off after this many results.
   localparam int BACKLOG_AT     = 40;
   localparam int BACKLOG_CYCLES = 1500;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 75;
   localparam int SETTLE_CYCLES  = 300;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample_x = '0;
   logic signed [SAMPLE_BITS-1:0] req_sample_y = '0;
   logic signed [SAMPLE_BITS-1:0] req_sample_z = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered_x;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered_y;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered_z;
   logic                   csr_write_en = 1'b0;
   csr_idx_type            csr_index = CSR_BLEND_FACTOR;
   logic [CFG_W-1:0]       csr_data = '0;

   // Samples waiting to be sent and filtered values awaited from the block.
   triple_type pending_samples[$];
   triple_type awaited_outputs[$];

   // Copy of the held values and the weight registers as the block sees them.
   triple_type held_now = '0;
   longint     blend_setting = 0;
   longint     jitter_setting = 0;

   logic idle_on = 1'b1;
   int   send_gap = 0;
   int   recv_hold = 0;
   int   results_seen = 0;
   int   fail_count = 0;

   adaptive_axis_smoothing_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_x   (req_sample_x),
      .req_sample_y   (req_sample_y),
      .req_sample_z   (req_sample_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_filtered_x (rsp_filtered_x),
      .rsp_filtered_y (rsp_filtered_y),
      .rsp_filtered_z (rsp_filtered_z),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #1 clock = ~clock;

   // New held value of one axis: the weight on the held value rises towards
   // one when the sample lies within the jitter distance.
   function automatic sample_type smooth_axis(sample_type held, sample_type sample);
      longint h, s, d, f, k, x, x2, x3, acc;
      h = longint'($signed(held));
      s = longint'($signed(sample));
      d = (h >= s) ? h - s : s - h;
      f = (blend_setting > longint'(ONE_Q)) ? 0 : blend_setting;
      k = f;
      if (jitter_setting != 0 && d < jitter_setting) begin
         x  = ((jitter_setting - d) <<< FRAC_BITS) / jitter_setting;
         x2 = (x * x) >>> FRAC_BITS;
         x3 = (x2 * x) >>> FRAC_BITS;
         k  = f + (((longint'(ONE_Q) - f) * x3) >>> FRAC_BITS);
      end
      acc = h * k + s * (longint'(ONE_Q) - k);
      return sample_type'(acc >>> FRAC_BITS);
   endfunction

   task automatic check_axis(string name, sample_type want, sample_type got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         fail_count++;
      end
   endtask

   // Request driver: holds the payload until accepted, then predicts the result.
   always @(posedge clock) begin : drive_requests
      logic       offer;
      triple_type upcoming;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!(req_valid && !req_ready)) begin
         if (req_valid) begin
            held_now.x = smooth_axis(held_now.x, req_sample_x);
            held_now.y = smooth_axis(held_now.y, req_sample_y);
            held_now.z = smooth_axis(held_now.z, req_sample_z);
            awaited_outputs.push_back(held_now);
            send_gap = idle_on ? int'($urandom_range(0, 4)) : 0;
         end
         offer = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_samples.size() > 0) begin
            upcoming = pending_samples.pop_front();
            req_sample_x <= upcoming.x;
            req_sample_y <= upcoming.y;
            req_sample_z <= upcoming.z;
            offer = 1'b1;
         end
         req_valid <= offer;
      end
   end

   // Result monitor: compares each accepted result with the oldest prediction.
   always @(posedge clock) begin : check_results
      triple_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_outputs.size() == 0) begin
               $error("result arrived with no request outstanding");
               fail_count++;
            end else begin
               want = awaited_outputs.pop_front();
               check_axis("filtered_x", want.x, rsp_filtered_x);
               check_axis("filtered_y", want.y, rsp_filtered_y);
               check_axis("filtered_z", want.z, rsp_filtered_z);
            end
            results_seen++;
            if (results_seen == BACKLOG_AT) begin
               recv_hold = BACKLOG_CYCLES;
            end else begin
               recv_hold = idle_on ? int'($urandom_range(0, 4)) : 0;
            end
         end else if (recv_hold > 0) begin
            recv_hold--;
         end
         rsp_ready <= (recv_hold == 0);
      end
   end

   task automatic write_register(csr_idx_type idx, logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Both registers are written only while the block has nothing in flight.
   task automatic set_weights(logic [WEIGHT_W-1:0] factor, dist_type distance);
      write_register(CSR_BLEND_FACTOR, CFG_W'(factor));
      write_register(CSR_JITTER_DISTANCE, CFG_W'(distance));
      blend_setting  = longint'(factor);
      jitter_setting = longint'(distance);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (pending_samples.size() != 0 || req_valid || awaited_outputs.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic void offer_sample(int x, int y, int z);
      triple_type item;
      item.x = sample_type'(x);
      item.y = sample_type'(y);
      item.z = sample_type'(z);
      pending_samples.push_back(item);
   endfunction

   // Mostly samples near a centre that jumps now and then, with some full-range
   // noise and some extremes of the range.
   function automatic sample_type pick_sample(int centre, int spread);
      int v;
      case ($urandom_range(0, 9))
         0: v = int'($urandom_range(0, 65535)) - 32768;
         1: begin
            case ($urandom_range(0, 3))
               0: v = -32768;
               1: v = 32767;
               2: v = 0;
               default: v = -1;
            endcase
         end
         default: v = centre + int'($urandom_range(0, 2 * spread)) - spread;
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return sample_type'(v);
   endfunction

   initial begin : stimulus
      int                  p, n, a, spread;
      int                  centre [AXIS_COUNT];
      triple_type          item;
      logic [WEIGHT_W-1:0] factor;
      dist_type            distance;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Zero factor and zero distance: samples pass straight through.
      set_weights(0, 0);
      offer_sample(32767, -32768, 0);
      offer_sample(-32768, 32767, -1);
      offer_sample(-1, 0, 32767);
      offer_sample(0, -1, -32768);
      wait_idle();

      // A factor just above one acts as zero.
      set_weights(17'd65537, 0);
      offer_sample(12345, -12345, 32767);
      offer_sample(-32768, 1, -2);
      wait_idle();

      // A weight of exactly one keeps the held values.
      set_weights(17'd65536, 16'd65535);
      offer_sample(32767, -32768, 100);
      offer_sample(-5, 7, 0);
      wait_idle();

      // Half weight with the widest distance: equal samples and full-range jumps.
      set_weights(17'd32768, 16'd65535);
      offer_sample(-32768, 1, -2);
      offer_sample(32767, -32768, 32767);
      offer_sample(0, 0, 0);
      offer_sample(1, -1, 2);
      wait_idle();

      // All-ones factor with distance one: only an exact match is smoothed.
      set_weights(17'h1FFFF, 16'd1);
      offer_sample(500, -500, 0);
      offer_sample(500, -500, 0);
      offer_sample(501, -499, 1);
      wait_idle();

      // Small factor with a moderate jitter window.
      set_weights(17'd1000, 16'd300);
      offer_sample(600, -400, 100);
      offer_sample(650, -350, -50);
      offer_sample(-32768, 32767, 400);
      offer_sample(-32700, 32700, 380);
      wait_idle();

      // Factor just below one at the range limits.
      set_weights(17'd65535, 16'd65535);
      offer_sample(32767, 32767, 32767);
      offer_sample(-32768, -32768, -32768);
      wait_idle();

      // Random phases, each under its own weight setting.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         idle_on = (p % 4 != 1);
         case ($urandom_range(0, 5))
            0: factor = 0;
            1: factor = 17'd65536;
            2: factor = WEIGHT_W'($urandom_range(65537, 131071));
            3: factor = WEIGHT_W'($urandom_range(0, 65536));
            4: factor = WEIGHT_W'($urandom_range(60000, 65535));
            default: factor = WEIGHT_W'($urandom_range(0, 8192));
         endcase
         case ($urandom_range(0, 4))
            0: distance = 0;
            1: distance = 16'd65535;
            2: distance = DIST_W'($urandom_range(1, 64));
            3: distance = DIST_W'($urandom_range(1, 4096));
            default: distance = DIST_W'($urandom_range(1, 65535));
         endcase
         set_weights(factor, distance);
         spread = (distance == 0) ? 256 : int'(distance);
         for (a = 0; a < AXIS_COUNT; a++)
            centre[a] = int'($urandom_range(0, 65535)) - 32768;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Now and then the centre of one axis jumps somewhere else.
            if ($urandom_range(0, 15) == 0)
               centre[$urandom_range(0, AXIS_COUNT - 1)] =
                  int'($urandom_range(0, 65535)) - 32768;
            item.x = pick_sample(centre[0], spread);
            item.y = pick_sample(centre[1], spread);
            item.z = pick_sample(centre[2], spread);
            pending_samples.push_back(item);
         end
         wait_idle();
      end

      // Allow for a late stray result before the verdict.
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog for a block that stops answering.
   initial begin : watchdog
      #3000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
